// ----- src/mieu_pkg.sv -----
package mieu_pkg;

	localparam int unsigned DataWidth  = 32;
	localparam int unsigned CmdWidth   = 6;
	localparam int unsigned LuiShift   = 16;
	localparam int unsigned BeqlSkip   = 8;
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [CmdWidth-1:0] {
		CMD_ADD  = 6'd0,  CMD_ADDI = 6'd1,  CMD_AND  = 6'd2,  CMD_ANDI = 6'd3,
		CMD_OR   = 6'd4,  CMD_ORI  = 6'd5,  CMD_XOR  = 6'd6,  CMD_XORI = 6'd7,
		CMD_NOR  = 6'd8,  CMD_SUB  = 6'd9,  CMD_LUI  = 6'd10, CMD_MUL  = 6'd11,
		CMD_MOVN = 6'd12, CMD_MOVZ = 6'd13, CMD_MULT = 6'd14, CMD_MADD = 6'd15,
		CMD_MSUB = 6'd16, CMD_DIV  = 6'd17, CMD_MFHI = 6'd18, CMD_MFLO = 6'd19,
		CMD_MTHI = 6'd20, CMD_MTLO = 6'd21, CMD_NOP  = 6'd22, CMD_B    = 6'd23,
		CMD_J    = 6'd24, CMD_BEQ  = 6'd25, CMD_BNE  = 6'd26, CMD_BGEZ = 6'd27,
		CMD_BGTZ = 6'd28, CMD_BLEZ = 6'd29, CMD_BLTZ = 6'd30, CMD_BEQL = 6'd31,
		CMD_JR   = 6'd32
	} cmd_t;

	// work class chosen by the front end
	typedef enum logic [2:0] {
		CLS_SIMPLE, CLS_MUL, CLS_MACC, CLS_DIV, CLS_HILO
	} cls_t;

	typedef enum logic [1:0] {
		BK_IDLE, BK_MUL, BK_DIV, BK_DONE
	} bk_state_t;

	// item handed from front to back
	typedef struct packed {
		cls_t                   cls;
		logic [CmdWidth-1:0]    cmd;
		logic [DataWidth-1:0]   a;
		logic [DataWidth-1:0]   b;
		logic [DataWidth-1:0]   res;
		logic                   wr;
		logic [DataWidth-1:0]   npc;
		logic                   taken;
	} op_t;

	typedef struct packed {
		logic [DataWidth-1:0] result;
		logic                 writes_register;
		logic [DataWidth-1:0] next_pc;
		logic                 branch_taken;
		logic                 divide_by_zero;
	} res_t;

	typedef struct packed {
		logic [CmdWidth-1:0]  command;
		logic [DataWidth-1:0] operand_a;
		logic [DataWidth-1:0] operand_b;
		logic [DataWidth-1:0] immediate;
		logic [DataWidth-1:0] dest_old_value;
		logic [DataWidth-1:0] current_pc;
		logic [DataWidth-1:0] branch_offset;
	} cmd_item_t;

endpackage

// ----- src/mieu_if.sv -----
interface mieu_cmd_if import mieu_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_item_t data;
	modport source  (output valid, output data, input ready);
	modport sink    (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

interface mieu_res_if import mieu_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;
	modport source  (output valid, output data, input ready);
	modport sink    (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

// ----- src/mips_integer_execute_unit.sv -----
// MIPS32 integer execute unit.
// Channels: cmd (sink) carries one decoded instruction per item; res
// (source) returns exactly one result item per instruction, in order.
// The front end decodes each item, finishes ALU, move and branch work at
// once and queues it (two entries) for the back end, which owns HI:LO.
// Simple ops pass through the queue and then the output register to res.
// mul, mult, madd, msub run in the back end as a registered 32x32
// multiply, then a HI:LO update for mult, madd and msub; div runs in the
// divider (one quotient bit per cycle); a zero divisor skips the divider
// and returns with divide_by_zero set.
// Simple items go one per cycle while res is ready and the back end is
// idle; a long op holds the back end and the queue accepts until full.
// Reset clears HI:LO to zero and empties the queue and output register.
// When res is stalled the output register holds, the back end takes no
// new item, and cmd ready drops once the queue is full.
module mips_integer_execute_unit import mieu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mieu_cmd_if.sink   cmd,
	mieu_res_if.source res
);

	logic op_valid, op_ready;
	op_t  op;

	mieu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (cmd),
		.op_valid (op_valid),
		.op       (op),
		.op_ready (op_ready)
	);

	mieu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.op_ready (op_ready),
		.out_ch   (res)
	);

endmodule

// ----- src/mieu_front.sv -----
module mieu_front import mieu_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	mieu_cmd_if.sink       in_ch,
	output logic           op_valid,
	output op_t            op,
	input  logic           op_ready
);

	cmd_item_t        c;
	logic [DataWidth-1:0] sum_pc;
	logic             cond;
	op_t              op_d;

	assign c = in_ch.data;
	assign sum_pc = c.current_pc + c.branch_offset;

	// decode and do the combinational work
	always_comb begin
		op_d       = '0;
		op_d.cls   = CLS_SIMPLE;
		op_d.cmd   = c.command;
		op_d.a     = c.operand_a;
		op_d.b     = c.operand_b;
		op_d.npc   = c.current_pc;
		cond       = 1'b0;
		case (c.command)
			CMD_ADD:  begin op_d.res = c.operand_a + c.operand_b; op_d.wr = 1'b1; end
			CMD_ADDI: begin op_d.res = c.operand_a + c.immediate; op_d.wr = 1'b1; end
			CMD_AND:  begin op_d.res = c.operand_a & c.operand_b; op_d.wr = 1'b1; end
			CMD_ANDI: begin op_d.res = c.operand_a & c.immediate; op_d.wr = 1'b1; end
			CMD_OR:   begin op_d.res = c.operand_a | c.operand_b; op_d.wr = 1'b1; end
			CMD_ORI:  begin op_d.res = c.operand_a | c.immediate; op_d.wr = 1'b1; end
			CMD_XOR:  begin op_d.res = c.operand_a ^ c.operand_b; op_d.wr = 1'b1; end
			CMD_XORI: begin op_d.res = c.operand_a ^ c.immediate; op_d.wr = 1'b1; end
			CMD_NOR:  begin op_d.res = ~(c.operand_a | c.operand_b); op_d.wr = 1'b1; end
			CMD_SUB:  begin op_d.res = c.operand_a - c.operand_b; op_d.wr = 1'b1; end
			CMD_LUI:  begin op_d.res = c.immediate << LuiShift; op_d.wr = 1'b1; end
			CMD_MOVN: begin
				op_d.res = (c.operand_b != '0) ? c.operand_a : c.dest_old_value;
				op_d.wr  = 1'b1;
			end
			CMD_MOVZ: begin
				op_d.res = (c.operand_b == '0) ? c.operand_a : c.dest_old_value;
				op_d.wr  = 1'b1;
			end
			CMD_MUL:  begin op_d.cls = CLS_MUL; op_d.wr = 1'b1; end
			CMD_MULT, CMD_MADD, CMD_MSUB: op_d.cls = CLS_MACC;
			CMD_DIV:  op_d.cls = CLS_DIV;
			CMD_MFHI, CMD_MFLO: begin op_d.cls = CLS_HILO; op_d.wr = 1'b1; end
			CMD_MTHI, CMD_MTLO: op_d.cls = CLS_HILO;
			CMD_B, CMD_J: cond = 1'b1;
			CMD_BEQ, CMD_BEQL: cond = (c.operand_a == c.operand_b);
			CMD_BNE:  cond = (c.operand_a != c.operand_b);
			CMD_BGEZ: cond = !c.operand_a[DataWidth-1];
			CMD_BGTZ: cond = !c.operand_a[DataWidth-1] && (c.operand_a != '0);
			CMD_BLEZ: cond = c.operand_a[DataWidth-1] || (c.operand_a == '0);
			CMD_BLTZ: cond = c.operand_a[DataWidth-1];
			CMD_JR:   begin op_d.taken = 1'b1; op_d.npc = c.operand_a; end
			default: ;
		endcase
		if (cond) begin
			op_d.taken = 1'b1;
			op_d.npc   = sum_pc;
		end else if (c.command == CMD_BEQL) begin
			op_d.npc = c.current_pc + DataWidth'(BeqlSkip);
		end
	end

	// two-entry queue toward the back end
	localparam int unsigned PtrW = $clog2(QueueDepth);
	op_t              mem_q [QueueDepth];
	logic [PtrW-1:0]  wp_q, rp_q;
	logic [PtrW:0]    cnt_q;
	logic             push, pop;

	assign in_ch.ready = (cnt_q != (PtrW+1)'(QueueDepth));
	assign push        = in_ch.valid && in_ch.ready;
	assign op_valid    = (cnt_q != '0);
	assign pop         = op_valid && op_ready;
	assign op          = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= op_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end

endmodule

// ----- src/mieu_div.sv -----
module mieu_div import mieu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DataWidth-1:0] dividend,
	input  logic [DataWidth-1:0] divisor,
	output logic                 done,
	output logic [DataWidth-1:0] quotient,
	output logic [DataWidth-1:0] remainder
);

	// one quotient bit per cycle on magnitudes, signs fixed at the end
	localparam int unsigned CntW = $clog2(DataWidth + 1);
	logic [DataWidth-1:0] q_q, d_q;
	logic [DataWidth:0]   r_q;
	logic [CntW-1:0]      cnt_q;
	logic                 busy_q, nq_q, nr_q;
	logic [DataWidth:0]   r_sh, r_sub;

	assign r_sh  = {r_q[DataWidth-1:0], q_q[DataWidth-1]};
	assign r_sub = r_sh - {1'b0, d_q};
	assign done  = busy_q && (cnt_q == '0);
	assign quotient  = nq_q ? -q_q : q_q;
	assign remainder = nr_q ? -r_q[DataWidth-1:0] : r_q[DataWidth-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			q_q  <= dividend[DataWidth-1] ? -dividend : dividend;
			d_q  <= divisor[DataWidth-1] ? -divisor : divisor;
			r_q  <= '0;
			nq_q <= dividend[DataWidth-1] ^ divisor[DataWidth-1];
			nr_q <= dividend[DataWidth-1];
		end else if (busy_q && cnt_q != '0) begin
			if (!r_sub[DataWidth]) r_q <= r_sub;
			else                   r_q <= r_sh;
			q_q <= {q_q[DataWidth-2:0], !r_sub[DataWidth]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(DataWidth);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- src/mieu_back.sv -----
module mieu_back import mieu_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	input  op_t            op,
	output logic           op_ready,
	mieu_res_if.source     out_ch
);

	bk_state_t            st_q, st_d;
	logic [2*DataWidth-1:0] hilo_q, prod_q;
	res_t                 res_q;
	logic                 out_v_q;
	logic                 take, div_start, div_done, dz;
	logic [DataWidth-1:0] quo, rem;
	logic [DataWidth-1:0] op_b;
	op_t                  cur_q;

	// divider samples the operands straight off the queue at start
	mieu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (op.a),
		.divisor   (op_b),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	assign op_b      = op.b;
	assign dz        = (cur_q.b == '0);
	assign op_ready  = (st_q == BK_IDLE) && (!out_v_q || out_ch.ready);
	assign take      = op_valid && op_ready;
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = res_q;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: if (take && (op.cls == CLS_MUL || op.cls == CLS_MACC)) begin
				st_d = BK_MUL;
			end else if (take && op.cls == CLS_DIV) begin
				st_d = (op_b == '0) ? BK_DONE : BK_DIV;
			end
			BK_MUL:  st_d = BK_DONE;
			BK_DIV:  if (div_done) st_d = BK_DONE;
			BK_DONE: if (!out_v_q || out_ch.ready) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		div_start = (st_q == BK_IDLE) && take && op.cls == CLS_DIV && op_b != '0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q  <= op;
			prod_q <= $signed(op.a) * $signed(op_b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= BK_IDLE;
			out_v_q <= 1'b0;
			hilo_q  <= '0;
			res_q   <= '0;
		end else begin
			st_q <= st_d;
			// output register: load from a simple or HI/LO item, a finished long op, or drain
			if (take && (op.cls == CLS_SIMPLE || op.cls == CLS_HILO)) begin
				out_v_q               <= 1'b1;
				res_q.result          <= (op.cmd == CMD_MFHI) ? hilo_q[2*DataWidth-1:DataWidth]
					: (op.cmd == CMD_MFLO) ? hilo_q[DataWidth-1:0] : op.res;
				res_q.writes_register <= op.wr;
				res_q.next_pc         <= op.npc;
				res_q.branch_taken    <= op.taken;
				res_q.divide_by_zero  <= 1'b0;
			end else if (st_q == BK_DONE && (!out_v_q || out_ch.ready)) begin
				out_v_q               <= 1'b1;
				res_q.result          <= (cur_q.cls == CLS_MUL) ? prod_q[DataWidth-1:0] : '0;
				res_q.writes_register <= cur_q.wr;
				res_q.next_pc         <= cur_q.npc;
				res_q.branch_taken    <= 1'b0;
				res_q.divide_by_zero  <= (cur_q.cls == CLS_DIV) && dz;
			end else if (out_v_q && out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			// HI:LO updates
			if (take && op.cmd == CMD_MTHI) begin
				hilo_q[2*DataWidth-1:DataWidth] <= op.a;
			end else if (take && op.cmd == CMD_MTLO) begin
				hilo_q[DataWidth-1:0] <= op.a;
			end else if (st_q == BK_MUL) begin
				if (cur_q.cmd == CMD_MULT)      hilo_q <= prod_q;
				else if (cur_q.cmd == CMD_MADD) hilo_q <= hilo_q + prod_q;
				else if (cur_q.cmd == CMD_MSUB) hilo_q <= hilo_q - prod_q;
			end else if (st_q == BK_DIV && div_done) begin
				hilo_q <= {rem, quo};
			end
		end
	end

endmodule
